[hdl/psue_pkg.sv]
// ----------------------------------------------------------------------------
// psue_pkg
// Shared types, constants and the cosine entry function for the swarm update engine.
// ----------------------------------------------------------------------------
package psue_pkg;

  localparam int SwarmSize     = 16;
  localparam int IdxW          = 4;
  localparam int CosDepth      = 1024;
  localparam int CosW          = 10;

  localparam logic [16:0] InertiaReset = 17'd32768;
  localparam logic [19:0] AccelReset   = 20'd131072;
  localparam logic [21:0] LimitReset   = 22'd327680;

  localparam logic [1:0] RegInertia  = 2'd0;
  localparam logic [1:0] RegAccelPer = 2'd1;
  localparam logic [1:0] RegAccelGlb = 2'd2;
  localparam logic [1:0] RegLimit    = 2'd3;

  localparam logic CmdLoad   = 1'b0;
  localparam logic CmdUpdate = 1'b1;

  localparam logic signed [25:0] PhaseScale = 26'sd16928921;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOVE,
    ST_VEL,
    ST_FIT,
    ST_RANK,
    ST_OUT
  } psue_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic move;
    logic vel;
    logic fit;
    logic rank;
  } psue_cmd_t;

  // cosine entry k of cos(2*pi*k/CosDepth) in signed Q1.16
  function automatic logic signed [17:0] cos_entry(input logic [CosW-1:0] k);
    logic [63:0] u, a, a2, t;
    logic        neg;
    logic signed [63:0] c, r;
    u   = ({54'd0, k} << 32) / 64'(CosDepth);
    neg = 1'b0;
    if (u > 64'h8000_0000) u = 64'h1_0000_0000 - u;
    if (u > 64'h4000_0000) begin
      u   = 64'h8000_0000 - u;
      neg = 1'b1;
    end
    a  = (u * 64'd6746518852) >> 32;
    a2 = (a * a) >> 30;
    t  = 64'd1073741824 - a2 / 64'd90;
    t  = 64'd1073741824 - ((a2 * t) >> 30) / 64'd56;
    t  = 64'd1073741824 - ((a2 * t) >> 30) / 64'd30;
    t  = 64'd1073741824 - ((a2 * t) >> 30) / 64'd12;
    c  = 64'sd1073741824 - $signed(((a2 * t) >> 30) / 64'd2);
    r  = (c + 64'sd8192) >>> 14;
    return neg ? 18'(-r) : 18'(r);
  endfunction

endpackage

[hdl/psue_ctrl.sv]
// ----------------------------------------------------------------------------
// psue_ctrl
// Sequencer: walks one item through move, velocity, fitness and rank steps; a load skips move and velocity.
// ----------------------------------------------------------------------------
module psue_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_cmd,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output psue_pkg::psue_cmd_t ctl
);
  import psue_pkg::*;

  psue_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = (in_cmd == CmdUpdate) ? ST_MOVE : ST_FIT;
      ST_MOVE: state_next = ST_VEL;
      ST_VEL:  state_next = ST_FIT;
      ST_FIT:  state_next = ST_RANK;
      ST_RANK: state_next = ST_OUT;
      ST_OUT:  if (out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctl       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        ctl.capture = in_valid;
      end
      ST_MOVE: ctl.move = 1'b1;
      ST_VEL:  ctl.vel  = 1'b1;
      ST_FIT:  ctl.fit  = 1'b1;
      ST_RANK: ctl.rank = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end
endmodule

[hdl/psue_datapath.sv]
// ----------------------------------------------------------------------------
// psue_datapath
// Particle table, motion and velocity arithmetic, fitness and best tracking.
// ----------------------------------------------------------------------------
module psue_datapath (
  input  logic                clk,
  input  logic                rst,
  input  psue_pkg::psue_cmd_t ctl,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_idx,
  input  logic [31:0]         cfg_data,
  input  logic                cmd,
  input  logic [3:0]          particle_index,
  input  logic signed [31:0]  init_position,
  input  logic signed [31:0]  init_velocity,
  input  logic [16:0]         rand_personal,
  input  logic [16:0]         rand_global,
  output logic [31:0]         fitness_value,
  output logic                personal_improved,
  output logic                global_improved,
  output logic [31:0]         best_fitness_out,
  output logic signed [31:0]  best_position_out
);
  import psue_pkg::*;

  logic [16:0] inertia;
  logic [19:0] accel_p, accel_g;
  logic [21:0] limit;

  logic signed [31:0] pos_mem  [SwarmSize];
  logic signed [31:0] vel_mem  [SwarmSize];
  logic signed [31:0] pbp_mem  [SwarmSize];
  logic [31:0]        pbf_mem  [SwarmSize];
  logic [31:0]        gbest_fit;
  logic signed [31:0] gbest_pos;

  logic               is_upd;
  logic [IdxW-1:0]    idx;
  logic signed [31:0] x, v, pb, v_old;
  logic [31:0]        pbf;
  logic [36:0]        k1_full, k2_full;
  logic [20:0]        k1, k2;
  logic signed [47:0] t_w;
  logic signed [55:0] t_p, t_g;
  logic [63:0]        sq;
  logic [31:0]        fit;
  logic               pimp, gimp;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inertia <= InertiaReset;
      accel_p <= AccelReset;
      accel_g <= AccelReset;
      limit   <= LimitReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        RegInertia:  inertia <= cfg_data[16:0];
        RegAccelPer: accel_p <= cfg_data[19:0];
        RegAccelGlb: accel_g <= cfg_data[19:0];
        RegLimit:    limit   <= cfg_data[21:0];
        default: ;
      endcase
    end
  end

  // combinational helpers
  logic signed [32:0] sum_xv;
  logic signed [31:0] x_sat, x_mv;
  logic signed [33:0] d_p, d_g;
  logic signed [49:0] v_sum;
  logic signed [63:0] fsum;
  logic signed [17:0] cval;
  logic [CosW-1:0]    cidx;
  logic signed [63:0] x_sq;
  logic signed [57:0] phase_full;

  // cosine lookup table, filled once from the series
  logic signed [17:0] cos_rom [CosDepth];

  initial begin
    for (int i = 0; i < CosDepth; i++) cos_rom[i] = cos_entry(CosW'(i));
  end

  assign k1_full = accel_p * rand_personal;
  assign k2_full = accel_g * rand_global;
  assign sum_xv  = 33'(x) + 33'(v);
  always_comb begin
    if (sum_xv > 33'sh0_7FFF_FFFF)       x_sat = 32'sh7FFF_FFFF;
    else if (sum_xv < -33'sh0_8000_0000) x_sat = 32'sh8000_0000;
    else                                 x_sat = sum_xv[31:0];
    if ($signed({x_sat[31], x_sat}) < -$signed({11'd0, limit}))  x_mv = 32'sd0;
    else if ($signed({x_sat[31], x_sat}) > $signed({11'd0, limit})) x_mv = 32'sd65536;
    else x_mv = x_sat;
  end
  assign d_p   = 34'(pb) - 34'(x);
  assign d_g   = 34'(gbest_pos) - 34'(x);
  assign v_sum = 50'(t_w >>> 16) + 50'(t_p >>> 16) + 50'(t_g >>> 16);
  // phase in turns, Q0.40 in the low bits
  assign x_sq       = x * x;
  assign phase_full = x * PhaseScale;
  assign cidx       = phase_full[39 -: CosW];
  assign fsum  = 64'($signed({2'b0, sq[63:16], 2'b0})) + 64'sd2621440
               - 64'(cval) * 64'sd40;

  // item sequence registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      is_upd <= cmd;
      idx    <= particle_index;
      k1     <= k1_full[36:16];
      k2     <= k2_full[36:16];
      if (cmd == CmdLoad) begin
        x <= init_position;
        v <= init_velocity;
      end else begin
        x <= pos_mem[particle_index];
        v <= vel_mem[particle_index];
      end
      pb  <= (cmd == CmdLoad) ? init_position : pbp_mem[particle_index];
      pbf <= (cmd == CmdLoad) ? 32'hFFFF_FFFF : pbf_mem[particle_index];
    end
    if (ctl.move) begin
      x     <= x_mv;
      v_old <= v;
    end
    if (ctl.vel) begin
      t_w <= 48'(v_old) * $signed({1'b0, inertia});
      t_p <= 56'(d_p) * $signed({1'b0, k1});
      t_g <= 56'(d_g) * $signed({1'b0, k2});
    end
    if (ctl.fit) begin
      if (is_upd) begin
        if (v_sum > 50'sh7FFF_FFFF)       v <= 32'sh7FFF_FFFF;
        else if (v_sum < -50'sh8000_0000) v <= 32'sh8000_0000;
        else                              v <= v_sum[31:0];
      end
      sq   <= x_sq;
      cval <= cos_rom[cidx];
    end
  end

  // rank and table write-back
  always_comb begin
    if (fsum < 0) fit = 32'd0;
    else if (fsum > 64'sh0_FFFF_FFFF) fit = 32'hFFFF_FFFF;
    else fit = fsum[31:0];
    pimp = fit < pbf;
    gimp = fit < gbest_fit;
  end

  always_ff @(posedge clk) begin
    if (ctl.rank) begin
      pos_mem[idx] <= x;
      vel_mem[idx] <= v;
      pbp_mem[idx] <= pimp ? x : pb;
      pbf_mem[idx] <= pimp ? fit : pbf;
      fitness_value     <= fit;
      personal_improved <= pimp;
      global_improved   <= gimp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gbest_fit <= 32'hFFFF_FFFF;
      gbest_pos <= 32'sd0;
    end else if (ctl.rank && gimp) begin
      gbest_fit <= fit;
      gbest_pos <= x;
    end
  end

  assign best_fitness_out  = gbest_fit;
  assign best_position_out = gbest_pos;
endmodule

[hdl/particle_swarm_update_engine_unit.sv]
// ----------------------------------------------------------------------------
// particle_swarm_update_engine_unit
// One-dimensional particle swarm step engine over a sixteen-entry table.
// ----------------------------------------------------------------------------
// One item at a time: the sequencer steps an update through move, velocity
// products, fitness products with the cosine lookup and rank, while a load
// skips move and velocity; the next item is taken in the cycle after the
// result transfer. Configuration writes are accepted whenever offered, as
// cfg_ready is held high.
module particle_swarm_update_engine_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [3:0]         particle_index,
  input  logic signed [31:0] init_position,
  input  logic signed [31:0] init_velocity,
  input  logic [16:0]        rand_personal,
  input  logic [16:0]        rand_global,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        fitness_value,
  output logic               personal_improved,
  output logic               global_improved,
  output logic [31:0]        best_fitness_out,
  output logic signed [31:0] best_position_out
);
  import psue_pkg::*;

  psue_cmd_t ctl;

  assign cfg_ready = 1'b1;

  psue_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_cmd(cmd), .in_ready,
    .out_valid, .out_ready, .ctl
  );

  psue_datapath u_dp (
    .clk, .rst, .ctl,
    .cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data,
    .cmd, .particle_index, .init_position, .init_velocity,
    .rand_personal, .rand_global,
    .fitness_value, .personal_improved, .global_improved,
    .best_fitness_out, .best_position_out
  );

  // input and output are never ready/valid together
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input and output both open");
  // global improvement implies global best equals reported fitness
  a_gimp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && global_improved) |-> (best_fitness_out == fitness_value))
    else $error("global best mismatch");
  // an accepted item produces no result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result too early");
endmodule
